[hw/rtl/rmst_pkg.sv]
// Shared types, command codes and the node merge function for the segment tree.
// Used by rmst_mem and range_minimum_segment_tree; depends on nothing else.
package rmst_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned IDX_W = 10;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] val;
  } node_t;

  localparam node_t NODE_EMPTY = '{ok: 1'b0, val: '0};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRD,
    S_WUPD,
    S_QRUN,
    S_FIN
  } state_e;

  // Minimum of two nodes; an empty node is the identity.
  function automatic node_t node_min(input node_t a, input node_t b);
    node_t res;
    if (a.ok && b.ok) begin
      res = (b.val < a.val) ? b : a;
    end else if (a.ok) begin
      res = a;
    end else if (b.ok) begin
      res = b;
    end else begin
      res = NODE_EMPTY;
    end
    return res;
  endfunction

endpackage

[hw/rtl/rmst_mem.sv]
// Node memory of the segment tree: one write port, two registered read ports.
// Depends on rmst_pkg for the node type.
module rmst_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  rmst_pkg::node_t     wdata_i,
  input  logic [AW-1:0]       raddr_a_i,
  input  logic [AW-1:0]       raddr_b_i,
  output rmst_pkg::node_t     rdata_a_o,
  output rmst_pkg::node_t     rdata_b_o
);

  rmst_pkg::node_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

[hw/rtl/range_minimum_segment_tree.sv]
// Range minimum segment tree: controller, query accumulator and result register.
// Depends on rmst_pkg and instantiates rmst_mem for the 2*NUM_ENTRIES tree nodes.
//
// Usage: one input channel (in_valid_i/in_ready_o) carries write and query beats;
// one output channel (out_valid_o/out_ready_i) carries one result beat per query.
// A write beat sets one leaf (value or empty) and refreshes every node on its path
// to the root; it produces no output beat. A query beat returns the minimum over
// the inclusive range, or result_empty_o = 1 with min_value_o = 0.
// A write refreshes L = log2(2*NUM_ENTRIES) - 1 tree levels (L = 10 for 1024 entries),
// with a read state (S_WRD) and a write-back state (S_WUPD) per level on the node
// memory; a query reads two nodes per level through the memory's two read ports.
// One beat is processed at a time. After reset the block clears all 2*NUM_ENTRIES
// nodes, one per cycle, and holds in_ready_o low until every node is cleared. A
// finished result waits in the output register while the block accepts further
// input; a query that finishes while that register is still full waits until the
// receiver takes the beat.
module range_minimum_segment_tree #(
  parameter int unsigned NUM_ENTRIES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  cmd_i,
  input  logic [rmst_pkg::IDX_W-1:0]            index_i,
  input  logic signed [rmst_pkg::VAL_W-1:0]     value_i,
  input  logic                                  value_empty_i,
  input  logic [rmst_pkg::IDX_W-1:0]            range_low_i,
  input  logic [rmst_pkg::IDX_W-1:0]            range_high_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [rmst_pkg::VAL_W-1:0]     min_value_o,
  output logic                                  result_empty_o
);

  localparam int unsigned DEPTH = 2 * NUM_ENTRIES;
  localparam int unsigned NW    = $clog2(DEPTH);
  localparam int unsigned LW    = NW + 1;
  localparam int unsigned CW    = (LW > rmst_pkg::IDX_W) ? LW : rmst_pkg::IDX_W;
  localparam logic [CW-1:0] N_C    = CW'(NUM_ENTRIES);
  localparam logic [NW-1:0] LAST_C = NW'(DEPTH - 1);

  rmst_pkg::state_e state_q, state_d;

  logic [NW-1:0]   clr_q, clr_d;
  logic [NW-1:0]   p_q, p_d;
  logic [LW-1:0]   l_q, l_d, r_q, r_d;
  logic            pend_q, pend_d;
  logic            takel_q, takel_d, taker_q, taker_d;
  rmst_pkg::node_t acc_q, acc_d;
  logic            out_valid_q, out_valid_d;
  logic signed [rmst_pkg::VAL_W-1:0] min_q, min_d;
  logic            empty_q, empty_d;

  logic            mem_we;
  logic [NW-1:0]   mem_waddr, mem_raddr_a, mem_raddr_b;
  rmst_pkg::node_t mem_wdata, mem_rdata_a, mem_rdata_b;

  logic [CW-1:0]   idx_ext, lo_ext, hi_ext, hi_clip;
  logic            idx_ok, range_ok, in_fire, out_free, out_load, q_more;
  logic [NW-1:0]   leaf;
  logic [LW-1:0]   r_dec;
  rmst_pkg::node_t new_leaf, acc_l, acc_r;

  assign idx_ext  = CW'(index_i);
  assign lo_ext   = CW'(range_low_i);
  assign hi_ext   = CW'(range_high_i);
  assign hi_clip  = (hi_ext > N_C - CW'(1)) ? N_C - CW'(1) : hi_ext;
  assign idx_ok   = idx_ext < N_C;
  assign range_ok = (lo_ext < N_C) && (lo_ext <= hi_clip);
  assign leaf     = NW'(idx_ext + N_C);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == rmst_pkg::S_FIN) && out_free;
  assign q_more   = l_q < r_q;
  assign r_dec    = r_q - LW'(1);
  assign new_leaf = value_empty_i ? rmst_pkg::NODE_EMPTY
                                  : rmst_pkg::node_t'{ok: 1'b1, val: value_i};

  assign acc_l = (pend_q && takel_q) ? rmst_pkg::node_min(acc_q, mem_rdata_a) : acc_q;
  assign acc_r = (pend_q && taker_q) ? rmst_pkg::node_min(acc_l, mem_rdata_b) : acc_l;

  rmst_mem #(
    .DEPTH(DEPTH),
    .AW   (NW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr_a_i(mem_raddr_a),
    .raddr_b_i(mem_raddr_b),
    .rdata_a_o(mem_rdata_a),
    .rdata_b_o(mem_rdata_b)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmst_pkg::S_CLEAR: begin
        if (clr_q == LAST_C) state_d = rmst_pkg::S_IDLE;
      end
      rmst_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == rmst_pkg::CMD_QUERY) begin
            state_d = range_ok ? rmst_pkg::S_QRUN : rmst_pkg::S_FIN;
          end else if (idx_ok) begin
            state_d = rmst_pkg::S_WRD;
          end
        end
      end
      rmst_pkg::S_WRD:  state_d = rmst_pkg::S_WUPD;
      rmst_pkg::S_WUPD: begin
        state_d = ((p_q >> 1) == '0) ? rmst_pkg::S_IDLE : rmst_pkg::S_WRD;
      end
      rmst_pkg::S_QRUN: begin
        if (!q_more) state_d = rmst_pkg::S_FIN;
      end
      rmst_pkg::S_FIN: begin
        if (out_free) state_d = rmst_pkg::S_IDLE;
      end
      default: state_d = rmst_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = p_q;
    mem_wdata   = rmst_pkg::node_min(mem_rdata_a, mem_rdata_b);
    mem_raddr_a = {p_q[NW-2:0], 1'b0};
    mem_raddr_b = {p_q[NW-2:0], 1'b1};
    unique case (state_q)
      rmst_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = rmst_pkg::NODE_EMPTY;
      end
      rmst_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        mem_we     = in_valid_i && (cmd_i == rmst_pkg::CMD_WRITE) && idx_ok;
        mem_waddr  = leaf;
        mem_wdata  = new_leaf;
      end
      rmst_pkg::S_WRD: begin
      end
      rmst_pkg::S_WUPD: begin
        mem_we = 1'b1;
      end
      rmst_pkg::S_QRUN: begin
        mem_raddr_a = l_q[NW-1:0];
        mem_raddr_b = r_dec[NW-1:0];
      end
      rmst_pkg::S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    clr_d       = clr_q + NW'(1);
    p_d         = p_q;
    l_d         = l_q;
    r_d         = r_q;
    pend_d      = 1'b0;
    takel_d     = takel_q;
    taker_d     = taker_q;
    acc_d       = acc_r;
    out_valid_d = out_valid_q && !out_ready_i;
    min_d       = min_q;
    empty_d     = empty_q;
    if (in_fire) begin
      p_d   = leaf >> 1;
      l_d   = LW'(lo_ext + N_C);
      r_d   = LW'(hi_clip + N_C + CW'(1));
      acc_d = rmst_pkg::NODE_EMPTY;
    end
    if (state_q == rmst_pkg::S_WUPD) begin
      p_d = p_q >> 1;
    end
    if ((state_q == rmst_pkg::S_QRUN) && q_more) begin
      pend_d  = 1'b1;
      takel_d = l_q[0];
      taker_d = r_q[0];
      l_d     = (l_q + LW'(l_q[0])) >> 1;
      r_d     = r_q >> 1;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      min_d       = acc_q.ok ? acc_q.val : '0;
      empty_d     = !acc_q.ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmst_pkg::S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    l_q     <= l_d;
    r_q     <= r_d;
    takel_q <= takel_d;
    taker_q <= taker_d;
    acc_q   <= acc_d;
    min_q   <= min_d;
    empty_q <= empty_d;
  end

  assign out_valid_o    = out_valid_q;
  assign min_value_o    = min_q;
  assign result_empty_o = empty_q;

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == rmst_pkg::S_FIN))
    else $error("result register loaded outside the finish state");

  a_no_write_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmst_pkg::S_QRUN || state_q == rmst_pkg::S_FIN) |-> !mem_we)
    else $error("node memory written during a query");

  a_upd_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmst_pkg::S_WUPD) |-> $past(state_q == rmst_pkg::S_WRD))
    else $error("node refresh without a preceding child read");

  a_drained_at_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmst_pkg::S_FIN) |-> !pend_q)
    else $error("query finished with a node read still pending");

endmodule

[tb/tb_range_minimum_segment_tree.sv]
`timescale 1ns / 1ps
// Testbench for range_minimum_segment_tree: directed and random write and query beats.
// A scoreboard class predicts query results from its own copy of the entries.
// Depends on rmst_pkg and the range_minimum_segment_tree RTL.
module tb_range_minimum_segment_tree;

  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned RANDOM_BEATS = 930;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned IDX_W = rmst_pkg::IDX_W;
  localparam int unsigned VAL_W = rmst_pkg::VAL_W;

  typedef struct {
    logic                    cmd;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    value_empty;
    logic [IDX_W-1:0]        range_low;
    logic [IDX_W-1:0]        range_high;
  } op_beat_t;

  typedef struct {
    logic signed [VAL_W-1:0] min_value;
    logic                    is_empty;
  } min_result_t;

  class min_scoreboard;
    logic                    leaf_ok[ENTRIES];
    logic signed [VAL_W-1:0] leaf_val[ENTRIES];
    min_result_t             expected_q[$];
    int unsigned             errors;

    function new();
      foreach (leaf_ok[i]) begin
        leaf_ok[i] = 1'b0;
        leaf_val[i] = '0;
      end
      errors = 0;
    endfunction

    task report(string what);
      $display("[%0t] error: %s", $time, what);
      errors++;
    endtask

    function void note_input(op_beat_t b);
      min_result_t r;
      int unsigned lo;
      int unsigned hi;
      int unsigned i;
      if (b.cmd == rmst_pkg::CMD_WRITE) begin
        if (32'(b.index) < ENTRIES) begin
          leaf_ok[b.index] = !b.value_empty;
          leaf_val[b.index] = b.value_empty ? '0 : b.value;
        end
      end else begin
        lo = 32'(b.range_low);
        hi = 32'(b.range_high);
        if (hi > ENTRIES - 1) hi = ENTRIES - 1;
        r.min_value = '0;
        r.is_empty = 1'b1;
        if (lo < ENTRIES && lo <= hi) begin
          for (i = lo; i <= hi; i++) begin
            if (leaf_ok[i] && (r.is_empty || leaf_val[i] < r.min_value)) begin
              r.min_value = leaf_val[i];
              r.is_empty = 1'b0;
            end
          end
        end
        expected_q.push_back(r);
      end
    endfunction

    task check_result(logic signed [VAL_W-1:0] got_min, logic got_empty);
      min_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat with no query outstanding (min %0d empty %0b)",
                         got_min, got_empty));
      end else begin
        exp_r = expected_q.pop_front();
        if (got_empty !== exp_r.is_empty)
          report($sformatf("result_empty %0b, expected %0b", got_empty, exp_r.is_empty));
        if (got_min !== exp_r.min_value)
          report($sformatf("min_value %0d, expected %0d", got_min, exp_r.min_value));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    cmd;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;
  logic                    value_empty;
  logic [IDX_W-1:0]        range_low;
  logic [IDX_W-1:0]        range_high;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] min_value;
  logic                    result_empty;

  min_scoreboard sb;
  int unsigned   beats_sent;
  int unsigned   results_seen;
  int unsigned   cycle_count;

  range_minimum_segment_tree #(
    .NUM_ENTRIES(ENTRIES)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .index_i       (index),
    .value_i       (value),
    .value_empty_i (value_empty),
    .range_low_i   (range_low),
    .range_high_i  (range_high),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .min_value_o   (min_value),
    .result_empty_o(result_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [VAL_W-1:0] random_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2: v = '0;
      3: v = -1;
      4: v = $signed($urandom_range(0, 64)) - 32;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic op_beat_t make_write(int unsigned idx, logic signed [VAL_W-1:0] v,
                                          logic empty_flag);
    op_beat_t b;
    b.cmd = rmst_pkg::CMD_WRITE;
    b.index = IDX_W'(idx);
    b.value = v;
    b.value_empty = empty_flag;
    b.range_low = IDX_W'($urandom);
    b.range_high = IDX_W'($urandom);
    return b;
  endfunction

  function automatic op_beat_t make_query(int unsigned lo, int unsigned hi);
    op_beat_t b;
    b.cmd = rmst_pkg::CMD_QUERY;
    b.index = IDX_W'($urandom);
    b.value = $urandom;
    b.value_empty = 1'($urandom_range(0, 1));
    b.range_low = IDX_W'(lo);
    b.range_high = IDX_W'(hi);
    return b;
  endfunction

  function automatic op_beat_t random_beat();
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(0, 99) < 45) begin
      if ($urandom_range(0, 3) == 0)
        lo = $urandom_range(0, 31);
      else
        lo = $urandom_range(0, ENTRIES - 1);
      return make_write(lo, random_value(), $urandom_range(0, 9) == 0);
    end
    lo = $urandom_range(0, ENTRIES - 1);
    case ($urandom_range(0, 5))
      0, 1: hi = $urandom_range(0, ENTRIES - 1);
      2: begin
        lo = $urandom_range(0, 40);
        hi = lo + $urandom_range(0, 15);
      end
      3: hi = (lo + $urandom_range(0, 15) > ENTRIES - 1) ? ENTRIES - 1
                                                         : lo + $urandom_range(0, 15);
      4: hi = lo;
      default: begin
        lo = $urandom_range(0, 1) ? 0 : lo;
        hi = ENTRIES - 1;
      end
    endcase
    return make_query(lo, hi);
  endfunction

  function automatic int unsigned draw_wait(int unsigned n, int unsigned quiet_lo,
                                            int unsigned quiet_hi);
    if (n >= quiet_lo && n < quiet_hi) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task send_beat(op_beat_t b);
    int unsigned gap;
    gap = draw_wait(beats_sent, 500, 600);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= b.cmd;
    index <= b.index;
    value <= b.value;
    value_empty <= b.value_empty;
    range_low <= b.range_low;
    range_high <= b.range_high;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b);
    beats_sent++;
  endtask

  initial begin
    int unsigned stall;
    bit held;
    held = 1'b0;
    forever begin
      if (results_seen == 30 && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = draw_wait(results_seen, 200, 260);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(min_value, result_empty);
      results_seen++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("range_minimum_segment_tree: mismatch");
    $finish;
  end

  initial begin
    sb = new();
    beats_sent = 0;
    results_seen = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    cmd <= rmst_pkg::CMD_WRITE;
    index <= '0;
    value <= '0;
    value_empty <= 1'b0;
    range_low <= '0;
    range_high <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(make_query(0, ENTRIES - 1));
    send_beat(make_write(0, 32'sh8000_0000, 1'b0));
    send_beat(make_write(ENTRIES - 1, 32'sh7fff_ffff, 1'b0));
    send_beat(make_write(512, -1, 1'b0));
    send_beat(make_write(513, 32'sh5555_aaaa, 1'b1));
    send_beat(make_write(514, 32'shffff_ffff, 1'b0));
    send_beat(make_query(0, ENTRIES - 1));
    send_beat(make_query(1, ENTRIES - 1));
    send_beat(make_query(ENTRIES - 1, ENTRIES - 1));
    send_beat(make_query(513, 513));
    send_beat(make_query(ENTRIES - 1, 0));
    send_beat(make_query(600, 599));
    send_beat(make_query(0, 0));
    send_beat(make_write(0, 32'sh1234_5678, 1'b1));
    send_beat(make_query(0, ENTRIES - 1));
    send_beat(make_query(0, 511));
    send_beat(make_write(513, 32'sh2aaa_5555, 1'b0));
    send_beat(make_query(513, ENTRIES - 1));
    send_beat(make_write(512, 32'sh7fff_ffff, 1'b0));
    send_beat(make_query(512, 513));
    send_beat(make_write(ENTRIES - 1, 0, 1'b1));
    send_beat(make_query(ENTRIES - 2, ENTRIES - 1));

    repeat (RANDOM_BEATS) send_beat(random_beat());
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("range_minimum_segment_tree: match");
    end else begin
      $display("range_minimum_segment_tree: mismatch");
    end
    $finish;
  end

endmodule
